// ===== sv/julia_set_membership_core_defines.svh =====
// ----------------------------------------------------------------------------
// Julia set membership core: assertion macros
// Shared property wrappers, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef JULIA_SET_MEMBERSHIP_CORE_DEFINES_SVH
`define JULIA_SET_MEMBERSHIP_CORE_DEFINES_SVH

// Same-cycle implication.
`define JSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Julia set membership package
// Word types, register map, reset values and controller interface types.
// ----------------------------------------------------------------------------
package jsm_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned FracBits  = 16;
  // Components at or beyond 2^7 whole units have escaped for any escape_sq.
  localparam int unsigned BoundLog2 = 7;

  // Start point: coordinate times an 18-bit step, plus a 32-bit origin.
  localparam int unsigned ProdW  = CoordBits + 19;
  localparam int unsigned StartW = ((ProdW > 32) ? ProdW : 32) + 1;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    RegCReal    = 3'd0,
    RegCImag    = 3'd1,
    RegMaxIter  = 3'd2,
    RegEscapeSq = 3'd3,
    RegXStart   = 3'd4,
    RegXStep    = 3'd5,
    RegYStart   = 3'd6,
    RegYStep    = 3'd7
  } jsm_reg_e;

  localparam logic [18:0] CRealRst    = 19'd0;
  localparam logic [18:0] CImagRst    = 19'd32768;
  localparam logic [15:0] MaxIterRst  = 16'd200;
  localparam logic [13:0] EscapeSqRst = 14'd10000;
  localparam logic [31:0] XStartRst   = 32'hFFFE_0000;
  localparam logic [17:0] XStepRst    = 18'd2185;
  localparam logic [31:0] YStartRst   = 32'h0002_0000;
  localparam logic [17:0] YStepRst    = 18'h3F333;

  typedef struct packed {
    logic [CoordBits-1:0] col;
    logic [CoordBits-1:0] row;
  } jsm_in_t;

  typedef struct packed {
    logic                 in_set;
    logic [CoordBits-1:0] out_col;
    logic [CoordBits-1:0] out_row;
  } jsm_out_t;

  typedef struct packed {
    logic [18:0] c_real;
    logic [18:0] c_imag;
    logic [15:0] max_iter;
    logic [13:0] escape_sq;
    logic [31:0] x_start;
    logic [17:0] x_step;
    logic [31:0] y_start;
    logic [17:0] y_step;
  } jsm_cfg_t;

  typedef struct packed {
    logic load_pix;
    logic init_z;
    logic step;
    logic finish;
    logic load_out;
  } jsm_cmd_t;

  typedef struct packed {
    logic escaped;
    logic last;
  } jsm_sts_t;

endpackage

// ===== sv/jsm_regs.sv =====
// ----------------------------------------------------------------------------
// Julia set membership configuration registers
// APB-style register file holding the Julia constant, iteration limit,
// escape radius and the pixel-to-plane mapping.
// ----------------------------------------------------------------------------
module jsm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jsm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [jsm_pkg::CfgDataW-1:0]  pwdata,
  output logic [jsm_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output jsm_pkg::jsm_cfg_t             cfg_o
);
  import jsm_pkg::*;

  jsm_cfg_t cfg_q, cfg_d;
  jsm_reg_e idx;
  logic     wr_en;

  assign idx    = jsm_reg_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegCReal:    cfg_d.c_real    = pwdata[18:0];
        RegCImag:    cfg_d.c_imag    = pwdata[18:0];
        RegMaxIter:  cfg_d.max_iter  = pwdata[15:0];
        RegEscapeSq: cfg_d.escape_sq = pwdata[13:0];
        RegXStart:   cfg_d.x_start   = pwdata[31:0];
        RegXStep:    cfg_d.x_step    = pwdata[17:0];
        RegYStart:   cfg_d.y_start   = pwdata[31:0];
        RegYStep:    cfg_d.y_step    = pwdata[17:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegCReal:    prdata = CfgDataW'(cfg_q.c_real);
      RegCImag:    prdata = CfgDataW'(cfg_q.c_imag);
      RegMaxIter:  prdata = CfgDataW'(cfg_q.max_iter);
      RegEscapeSq: prdata = CfgDataW'(cfg_q.escape_sq);
      RegXStart:   prdata = CfgDataW'(cfg_q.x_start);
      RegXStep:    prdata = CfgDataW'(cfg_q.x_step);
      RegYStart:   prdata = CfgDataW'(cfg_q.y_start);
      RegYStep:    prdata = CfgDataW'(cfg_q.y_step);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_real    <= CRealRst;
      cfg_q.c_imag    <= CImagRst;
      cfg_q.max_iter  <= MaxIterRst;
      cfg_q.escape_sq <= EscapeSqRst;
      cfg_q.x_start   <= XStartRst;
      cfg_q.x_step    <= XStepRst;
      cfg_q.y_start   <= YStartRst;
      cfg_q.y_step    <= YStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/jsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Julia set membership controller
// Sequences one pixel at a time: capture, start point, iterate, hand off.
// ----------------------------------------------------------------------------
module jsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  jsm_pkg::jsm_sts_t sts_i,
  output jsm_pkg::jsm_cmd_t cmd_o
);
  import jsm_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StInit = 4'b0010,
    StIter = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  jsm_cmd_t cmd;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd.load_pix = 1'b1;
          state_d      = StInit;
        end
      end
      StInit: begin
        cmd.init_z = 1'b1;
        state_d    = StIter;
      end
      StIter: begin
        // The bound test runs before every step and once after the last one.
        if (sts_i.escaped || sts_i.last) begin
          cmd.finish = 1'b1;
          state_d    = StDone;
        end else begin
          cmd.step = 1'b1;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/jsm_dpath.sv =====
// ----------------------------------------------------------------------------
// Julia set membership datapath
// Start-point mapping, the complex-square iteration register with its three
// multipliers, the escape test, the iteration counter and the result word.
// ----------------------------------------------------------------------------
module jsm_dpath #(
  parameter int unsigned FRAC_BITS = jsm_pkg::FracBits
) (
  input  logic              clk_i,
  input  jsm_pkg::jsm_cfg_t cfg_i,
  input  jsm_pkg::jsm_in_t  in_data_i,
  input  jsm_pkg::jsm_cmd_t cmd_i,
  output jsm_pkg::jsm_sts_t sts_o,
  output jsm_pkg::jsm_out_t out_data_o
);
  import jsm_pkg::*;

  localparam int unsigned LimBits = FRAC_BITS + BoundLog2;
  localparam int unsigned OpW     = LimBits + 1;
  localparam int unsigned PrW     = 2 * OpW;
  localparam int unsigned ZW      = (StartW > FRAC_BITS + 18) ? StartW : FRAC_BITS + 18;
  localparam int unsigned XW      = (PrW > ZW) ? PrW : ZW;

  // True when the magnitude reaches the bound of 2^BoundLog2 whole units.
  function automatic logic too_big(logic signed [ZW-1:0] v);
    logic [ZW-LimBits-1:0] hi;
    logic                  all0;
    logic                  all1;
    hi   = v[ZW-1:LimBits];
    all0 = ~|hi;
    all1 = &hi;
    return !(all0 || (all1 && |v[LimBits-1:0]));
  endfunction

  logic [CoordBits-1:0]   col_q, row_q;
  logic signed [ZW-1:0]   re_q, im_q, re_d, im_d;
  logic [15:0]            cnt_q;
  logic                   member_q;
  jsm_out_t               out_q;

  // Start point.
  logic signed [ProdW-1:0]  col_ext, row_ext, xstep_ext, ystep_ext, xprod, yprod;
  logic signed [StartW-1:0] x0, y0;

  assign col_ext   = $signed(ProdW'(col_q));
  assign row_ext   = $signed(ProdW'(row_q));
  assign xstep_ext = ProdW'($signed(cfg_i.x_step));
  assign ystep_ext = ProdW'($signed(cfg_i.y_step));
  assign xprod     = col_ext * xstep_ext;
  assign yprod     = row_ext * ystep_ext;
  assign x0        = StartW'($signed(cfg_i.x_start)) + StartW'(xprod);
  assign y0        = StartW'($signed(cfg_i.y_start)) + StartW'(yprod);

  // Squares and cross product; operands are exact whenever no bound is hit.
  logic signed [OpW-1:0] re_op, im_op;
  logic signed [PrW-1:0] re_x, im_x, rr, ii, ri;
  logic [PrW-1:0]        mag_sq, lim_sq;
  logic                  big, escaped;

  assign re_op  = re_q[OpW-1:0];
  assign im_op  = im_q[OpW-1:0];
  assign re_x   = PrW'(re_op);
  assign im_x   = PrW'(im_op);
  assign rr     = re_x * re_x;
  assign ii     = im_x * im_x;
  assign ri     = re_x * im_x;
  assign mag_sq = $unsigned(rr) + $unsigned(ii);
  assign lim_sq = PrW'({cfg_i.escape_sq, {(2 * FRAC_BITS){1'b0}}});
  assign big    = too_big(re_q) || too_big(im_q);
  assign escaped = big || (mag_sq > lim_sq);

  // Next z; the arithmetic shift rounds toward minus infinity.
  logic signed [XW-1:0] diff, twice, re_sum, im_sum;

  assign diff   = XW'(rr) - XW'(ii);
  assign twice  = XW'(ri) <<< 1;
  assign re_sum = (diff >>> FRAC_BITS) + XW'($signed(cfg_i.c_real));
  assign im_sum = (twice >>> FRAC_BITS) + XW'($signed(cfg_i.c_imag));

  always_comb begin
    re_d = re_q;
    im_d = im_q;
    if (cmd_i.init_z) begin
      re_d = ZW'(x0);
      im_d = ZW'(y0);
    end else if (cmd_i.step) begin
      re_d = re_sum[ZW-1:0];
      im_d = im_sum[ZW-1:0];
    end
  end

  assign sts_o.escaped = escaped;
  assign sts_o.last    = (cnt_q == cfg_i.max_iter);
  assign out_data_o    = out_q;

  always_ff @(posedge clk_i) begin
    re_q <= re_d;
    im_q <= im_d;
    if (cmd_i.load_pix) begin
      col_q <= in_data_i.col;
      row_q <= in_data_i.row;
    end
    if (cmd_i.init_z) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 16'd1;
    end
    if (cmd_i.finish) begin
      member_q <= !escaped;
    end
    if (cmd_i.load_out) begin
      out_q.in_set  <= member_q;
      out_q.out_col <= col_q;
      out_q.out_row <= row_q;
    end
  end

endmodule

// ===== sv/julia_set_membership_core.sv =====
// ----------------------------------------------------------------------------
// Julia set membership core
// Each accepted pixel is captured, mapped to its start point, iterated for n
// map steps, where n is the number taken before escape (at most max_iter),
// and then handed off; a new pixel is taken only once the last is handed off.
// The single z register with its squaring multipliers does one step per cycle.
// Reset clears the sequencer and output valid and loads the register defaults.
// ----------------------------------------------------------------------------
`include "julia_set_membership_core_defines.svh"

module julia_set_membership_core #(
  parameter int unsigned FRAC_BITS = jsm_pkg::FracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  jsm_pkg::jsm_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output jsm_pkg::jsm_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jsm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [jsm_pkg::CfgDataW-1:0]  pwdata,
  output logic [jsm_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import jsm_pkg::*;

  jsm_cfg_t cfg;
  jsm_cmd_t cmd;
  jsm_sts_t sts;

  jsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jsm_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // An accepted word always starts a fresh orbit in the following cycle.
  `JSM_ASSERT_NXT(a_accept_inits, in_valid_i && in_ready_o, cmd.init_z, "accept without init")
  // A finished result never overwrites a word still waiting downstream.
  `JSM_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_o || out_ready_i, "result overwritten")
  // The map never advances past an escape or past the iteration limit.
  `JSM_ASSERT_IMP(a_step_legal, cmd.step, !sts.escaped && !sts.last, "illegal step")

endmodule
